// ===== hdl/sew_pkg.sv =====
`default_nettype none

package sew_pkg;

  // Field widths of the channels
  localparam int ADDR_W = 15;
  localparam int DATA_W = 64;

  // Command codes on the event channel
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_XFER  = 2'd2;

  // Access size codes (anything else means eight bytes)
  localparam logic [1:0] SIZE_2 = 2'd0;
  localparam logic [1:0] SIZE_4 = 2'd1;

  // EEPROM opcodes
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Event class decided by the front
  typedef enum logic [1:0] {
    EV_REQ  = 2'd0,
    EV_XFER = 2'd1,
    EV_NOP  = 2'd2
  } ev_kind_t;

  // Classified event as it sits in the queue
  typedef struct packed {
    ev_kind_t            kind;
    logic                is_write;
    logic [1:0]          size_sel;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   wdata;    // already left aligned for MSB-first send
    logic [7:0]          rx_byte;
  } q_entry_t;

  // One result item
  typedef struct packed {
    logic              spi_valid;
    logic [7:0]        tx_byte;
    logic              new_frame;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
    logic              rejected;
  } result_t;

  // Sequencer phases
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_SR_CMD   = 8'b0000_0010,
    PH_SR_DUMMY = 8'b0000_0100,
    PH_WEN      = 8'b0000_1000,
    PH_CMD      = 8'b0001_0000,
    PH_AHI      = 8'b0010_0000,
    PH_ALO      = 8'b0100_0000,
    PH_DATA     = 8'b1000_0000
  } phase_t;

  // Number of bytes in an access
  function automatic logic [3:0] size_bytes(input logic [1:0] code);
    logic [3:0] n;
    unique case (code)
      SIZE_2:  n = 4'd2;
      SIZE_4:  n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sew_if.sv =====
`default_nettype none

// Event channel: requests and completed SPI exchanges
interface sew_in_if;
  import sew_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [1:0]        size_code;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [7:0]        rx_byte;

  modport source (output valid, command, size_code, address, write_data, rx_byte,
                  input ready);
  modport sink   (input valid, command, size_code, address, write_data, rx_byte,
                  output ready);
endinterface

// Result channel: next SPI byte, done or reject
interface sew_out_if;
  import sew_pkg::*;
  logic              valid;
  logic              ready;
  logic              spi_valid;
  logic [7:0]        tx_byte;
  logic              new_frame;
  logic              done_res;
  logic [DATA_W-1:0] read_data;
  logic              rejected;

  modport source (output valid, spi_valid, tx_byte, new_frame, done_res, read_data,
                  rejected, input ready);
  modport sink   (input valid, spi_valid, tx_byte, new_frame, done_res, read_data,
                  rejected, output ready);
endinterface

`default_nettype wire

// ===== hdl/spi_eeprom_word_access.sv =====
// SPI EEPROM word access sequencer. Read and write requests of 2, 4 or 8
// bytes and completed SPI byte exchanges arrive on the evt channel; every
// event gives exactly one result on the res channel: the next byte to shift
// (with a chip-select pulse flag), a done result carrying the read value, a
// reject for a request made while an access is running, or an all-zero
// result for an event with no meaning. A front stage classifies each event
// into a two-entry queue; the back sequencer retires one event per clock
// into a result register while the result channel does not stall, so one
// transaction per cycle is sustained; each event passes through a queue
// slot and then the result register. Every access is preceded by status
// polling, writes also by a write-enable frame; SPI pins and clocking are outside.
`default_nettype none

module spi_eeprom_word_access import sew_pkg::*; #(
  parameter int ADDR_BITS = 15
) (
  input  logic      clk,
  input  logic      rst,
  sew_in_if.sink    evt,
  sew_out_if.source res
);

  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  q_entry_t wr_entry;
  q_entry_t rd_entry;

  sew_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .evt    (evt),
    .q_full (q_full),
    .push   (push),
    .entry  (wr_entry)
  );

  sew_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rd_entry  (rd_entry)
  );

  sew_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .entry   (rd_entry),
    .pop     (pop),
    .res     (res)
  );

endmodule

`default_nettype wire

// ===== hdl/sew_front.sv =====
`default_nettype none

module sew_front import sew_pkg::*; #(
  parameter int ADDR_BITS = 15
) (
  sew_in_if.sink   evt,
  input  logic     q_full,
  output logic     push,
  output q_entry_t entry
);

  logic [ADDR_W-1:0] addr_mask;

  // Address bits beyond ADDR_BITS are dropped
  always_comb begin
    for (int i = 0; i < ADDR_W; i++) begin
      addr_mask[i] = (i < ADDR_BITS);
    end
  end

  assign evt.ready = !q_full;
  assign push      = evt.valid && !q_full;

  // Classify the transaction and pre-align the write data
  always_comb begin
    entry          = '0;
    entry.is_write = (evt.command == CMD_WRITE);
    entry.size_sel = evt.size_code;
    entry.address  = evt.address & addr_mask;
    entry.rx_byte  = evt.rx_byte;
    if (evt.command == CMD_READ || evt.command == CMD_WRITE) begin
      entry.kind = EV_REQ;
    end else if (evt.command == CMD_XFER) begin
      entry.kind = EV_XFER;
    end else begin
      entry.kind = EV_NOP;
    end
    unique case (evt.size_code)
      SIZE_2:  entry.wdata = {evt.write_data[15:0], 48'd0};
      SIZE_4:  entry.wdata = {evt.write_data[31:0], 32'd0};
      default: entry.wdata = evt.write_data;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sew_queue.sv =====
`default_nettype none

module sew_queue import sew_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t rd_entry
);

  q_entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sew_back.sv =====
`default_nettype none

module sew_back import sew_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  q_entry_t  entry,
  output logic      pop,
  sew_out_if.source res
);

  phase_t            phase, phase_next;
  logic              is_write, is_write_next;
  logic [1:0]        size_sel, size_sel_next;
  logic [ADDR_W-1:0] saved_address, saved_address_next;
  logic [DATA_W-1:0] data_shift, data_shift_next;
  logic [DATA_W-1:0] read_accum, read_accum_next;
  logic [3:0]        bytes_left, bytes_left_next;
  logic              busy;
  logic              res_valid;
  result_t           res_q, res_next;
  logic [3:0]        left_dec;
  logic [DATA_W-1:0] accum_shift;
  logic [7:0]        data_byte;

  assign busy = (phase != PH_IDLE);
  assign pop  = q_valid && (!res_valid || res.ready);

  assign left_dec    = (bytes_left != '0) ? bytes_left - 4'd1 : bytes_left;
  assign accum_shift = {read_accum[DATA_W-9:0], entry.rx_byte};
  assign data_byte   = is_write ? data_shift[DATA_W-1:DATA_W-8] : 8'd0;

  // One sequencer step for the event at the head of the queue
  always_comb begin
    phase_next         = phase;
    is_write_next      = is_write;
    size_sel_next      = size_sel;
    saved_address_next = saved_address;
    data_shift_next    = data_shift;
    read_accum_next    = read_accum;
    bytes_left_next    = bytes_left;
    res_next           = '0;
    unique case (entry.kind)
      EV_REQ: begin
        if (busy) begin
          res_next.rejected = 1'b1;
        end else begin
          phase_next         = PH_SR_CMD;
          is_write_next      = entry.is_write;
          size_sel_next      = entry.size_sel;
          saved_address_next = entry.address;
          data_shift_next    = entry.wdata;
          read_accum_next    = '0;
          bytes_left_next    = '0;
          res_next.spi_valid = 1'b1;
          res_next.tx_byte   = OP_RDSR;
          res_next.new_frame = 1'b1;
        end
      end
      EV_XFER: begin
        if (busy) begin
          unique case (phase)
            PH_SR_CMD: begin
              phase_next         = PH_SR_DUMMY;
              res_next.spi_valid = 1'b1;
            end
            PH_SR_DUMMY: begin
              res_next.spi_valid = 1'b1;
              res_next.new_frame = 1'b1;
              if (entry.rx_byte[0]) begin
                // write still in progress: poll again
                phase_next       = PH_SR_CMD;
                res_next.tx_byte = OP_RDSR;
              end else if (is_write) begin
                phase_next       = PH_WEN;
                res_next.tx_byte = OP_WREN;
              end else begin
                phase_next       = PH_CMD;
                res_next.tx_byte = OP_READ;
              end
            end
            PH_WEN: begin
              phase_next         = PH_CMD;
              res_next.spi_valid = 1'b1;
              res_next.tx_byte   = OP_WRITE;
              res_next.new_frame = 1'b1;
            end
            PH_CMD: begin
              phase_next         = PH_AHI;
              res_next.spi_valid = 1'b1;
              res_next.tx_byte   = 8'(saved_address >> 8);
            end
            PH_AHI: begin
              phase_next         = PH_ALO;
              res_next.spi_valid = 1'b1;
              res_next.tx_byte   = {saved_address[7:1], 1'b0};
            end
            PH_ALO: begin
              phase_next         = PH_DATA;
              bytes_left_next    = size_bytes(size_sel);
              res_next.spi_valid = 1'b1;
              res_next.tx_byte   = data_byte;
              if (is_write) begin
                data_shift_next = {data_shift[DATA_W-9:0], 8'd0};
              end
            end
            PH_DATA: begin
              if (!is_write) begin
                read_accum_next = accum_shift;
              end
              bytes_left_next = left_dec;
              if (left_dec == '0) begin
                phase_next         = PH_IDLE;
                res_next.done_res  = 1'b1;
                res_next.read_data = is_write ? '0 : accum_shift;
              end else begin
                res_next.spi_valid = 1'b1;
                res_next.tx_byte   = data_byte;
                if (is_write) begin
                  data_shift_next = {data_shift[DATA_W-9:0], 8'd0};
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
      end
      if (pop) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Access context and result register
  always_ff @(posedge clk) begin
    if (pop) begin
      is_write      <= is_write_next;
      size_sel      <= size_sel_next;
      saved_address <= saved_address_next;
      data_shift    <= data_shift_next;
      read_accum    <= read_accum_next;
      bytes_left    <= bytes_left_next;
      res_q         <= res_next;
    end
  end

  assign res.valid     = res_valid;
  assign res.spi_valid = res_q.spi_valid;
  assign res.tx_byte   = res_q.tx_byte;
  assign res.new_frame = res_q.new_frame;
  assign res.done_res  = res_q.done_res;
  assign res.read_data = res_q.read_data;
  assign res.rejected  = res_q.rejected;

endmodule

`default_nettype wire

// ===== hdl/sew_check.sv =====
`default_nettype none

module sew_check (
  input wire        clk,
  input wire        rst,
  input wire        res_valid,
  input wire        res_ready,
  input wire        spi_valid,
  input wire [7:0]  tx_byte,
  input wire        new_frame,
  input wire        done_res,
  input wire [63:0] read_data,
  input wire        rejected
);

  // A stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(tx_byte) && $stable(read_data)
      && $stable(done_res))
    else $error("result changed while stalled");

  // A frame start always carries a byte to send
  a_frame_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && new_frame |-> spi_valid && !done_res && !rejected)
    else $error("frame start without a byte");

  // Done releases the bus and rejects nothing
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !spi_valid && !new_frame && !rejected && tx_byte == 8'd0)
    else $error("done result drives the bus");

  // Read data only shows up on done
  a_rdata_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> read_data == 64'd0)
    else $error("read data outside done");

  // A reject carries nothing else
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && rejected |-> !spi_valid && !done_res && tx_byte == 8'd0)
    else $error("reject with payload");

endmodule

bind spi_eeprom_word_access sew_check u_sew_check (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .spi_valid (res.spi_valid),
  .tx_byte   (res.tx_byte),
  .new_frame (res.new_frame),
  .done_res  (res.done_res),
  .read_data (res.read_data),
  .rejected  (res.rejected)
);

`default_nettype wire

// ===== test/spi_eeprom_word_access_tb.sv =====
`default_nettype none

module spi_eeprom_word_access_tb;
  import sew_pkg::*;

  // Codes the package does not name
  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic [1:0] SIZE_8_ALT = 2'd3;

  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD    = 300;

  // Expected results of the access sequencer, predicted per accepted transaction
  class access_scoreboard;
    result_t expected_q[$];
    int errors;

    // Sequencer state as the predictor sees it
    bit                busy;
    phase_t            phase;
    bit                is_write;
    logic [1:0]        size_sel;
    logic [ADDR_W-1:0] saved_addr;
    logic [63:0]       data_shift;
    logic [63:0]       read_accum;
    int unsigned       bytes_left;

    function new();
      errors     = 0;
      busy       = 1'b0;
      phase      = PH_IDLE;
      is_write   = 1'b0;
      size_sel   = '0;
      saved_addr = '0;
      data_shift = '0;
      read_accum = '0;
      bytes_left = 0;
    endfunction

    function int unsigned byte_count(logic [1:0] code);
      case (code)
        SIZE_2:  return 2;
        SIZE_4:  return 4;
        default: return 8;
      endcase
    endfunction

    // Next data byte on the wire: write data MSB first, dummy zero on reads
    function logic [7:0] shift_out();
      logic [7:0] b;
      b = 8'h00;
      if (is_write) begin
        b = data_shift[63:56];
        data_shift = data_shift << 8;
      end
      return b;
    endfunction

    function result_t predict(logic [1:0] cmd, logic [1:0] size, logic [ADDR_W-1:0] addr,
                              logic [63:0] wdata, logic [7:0] rx);
      result_t r;
      int unsigned n;
      r = '0;
      // Requests: start an access, or reject while one runs
      if (cmd == CMD_READ || cmd == CMD_WRITE) begin
        if (busy) begin
          r.rejected = 1'b1;
          return r;
        end
        busy       = 1'b1;
        is_write   = (cmd == CMD_WRITE);
        size_sel   = size;
        saved_addr = addr;
        n          = byte_count(size);
        data_shift = (n == 8) ? wdata : (wdata << (64 - 8 * n));
        read_accum = '0;
        bytes_left = 0;
        phase      = PH_SR_CMD;
        r.spi_valid = 1'b1;
        r.tx_byte   = OP_RDSR;
        r.new_frame = 1'b1;
        return r;
      end
      // Exchange while idle and unused command: all-zero result
      if (cmd != CMD_XFER || !busy) return r;

      case (phase)
        PH_SR_CMD: begin
          phase = PH_SR_DUMMY;
          r.spi_valid = 1'b1;
        end
        PH_SR_DUMMY: begin
          r.spi_valid = 1'b1;
          r.new_frame = 1'b1;
          if (rx[0]) begin
            phase = PH_SR_CMD;
            r.tx_byte = OP_RDSR;
          end else if (is_write) begin
            phase = PH_WEN;
            r.tx_byte = OP_WREN;
          end else begin
            phase = PH_CMD;
            r.tx_byte = OP_READ;
          end
        end
        PH_WEN: begin
          phase = PH_CMD;
          r.spi_valid = 1'b1;
          r.tx_byte   = OP_WRITE;
          r.new_frame = 1'b1;
        end
        PH_CMD: begin
          phase = PH_AHI;
          r.spi_valid = 1'b1;
          r.tx_byte   = 8'(saved_addr >> 8);
        end
        PH_AHI: begin
          phase = PH_ALO;
          r.spi_valid = 1'b1;
          r.tx_byte   = saved_addr[7:0] & 8'hFE;
        end
        PH_ALO: begin
          phase = PH_DATA;
          bytes_left = byte_count(size_sel);
          r.spi_valid = 1'b1;
          r.tx_byte   = shift_out();
        end
        PH_DATA: begin
          if (!is_write) read_accum = {read_accum[55:0], rx};
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) begin
            busy  = 1'b0;
            phase = PH_IDLE;
            r.done_res  = 1'b1;
            r.read_data = is_write ? 64'h0 : read_accum;
          end else begin
            r.spi_valid = 1'b1;
            r.tx_byte   = shift_out();
          end
        end
        default: begin
          busy  = 1'b0;
          phase = PH_IDLE;
        end
      endcase
      return r;
    endfunction

    function void note_event(logic [1:0] cmd, logic [1:0] size, logic [ADDR_W-1:0] addr,
                             logic [63:0] wdata, logic [7:0] rx);
      expected_q.push_back(predict(cmd, size, addr, wdata, rx));
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("spi_valid", 64'(want.spi_valid), 64'(got.spi_valid));
      check_field("tx_byte",   64'(want.tx_byte),   64'(got.tx_byte));
      check_field("new_frame", 64'(want.new_frame), 64'(got.new_frame));
      check_field("done_res",  64'(want.done_res),  64'(got.done_res));
      check_field("read_data", want.read_data,      got.read_data);
      check_field("rejected",  64'(want.rejected),  64'(got.rejected));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  sew_in_if  evt();
  sew_out_if res();

  spi_eeprom_word_access #(.ADDR_BITS(ADDR_W)) dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res)
  );

  access_scoreboard sb;

  int burst_left   = 5;
  int access_items = 0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;
  int stall_mode   = 0;
  int stall_left   = 0;
  int stall_cyc    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both channels; inputs are noted before results are checked
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (evt.valid && evt.ready)
        sb.note_event(evt.command, evt.size_code, evt.address, evt.write_data, evt.rx_byte);
      if (res.valid && res.ready) begin
        got.spi_valid = res.spi_valid;
        got.tx_byte   = res.tx_byte;
        got.new_frame = res.new_frame;
        got.done_res  = res.done_res;
        got.read_data = res.read_data;
        got.rejected  = res.rejected;
        sb.check_result(got);
      end
    end
  end

  // Result side backpressure: one long hold-off, otherwise changing patterns
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      res.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 128);
      end
      stall_left--;
      stall_cyc++;
      case (stall_mode)
        0:       res.ready <= 1'b1;
        1:       res.ready <= 1'($urandom_range(0, 1));
        2:       res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= 1'(8'b1011_0110 >> (stall_cyc % 8));
      endcase
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one transaction and hold it until taken; bursts end in random gaps
  task automatic send_event(input logic [1:0] cmd, input logic [1:0] size,
                            input logic [ADDR_W-1:0] addr, input logic [63:0] wdata,
                            input logic [7:0] rx);
    int gap;
    evt.valid      <= 1'b1;
    evt.command    <= cmd;
    evt.size_code  <= size;
    evt.address    <= addr;
    evt.write_data <= wdata;
    evt.rx_byte    <= rx;
    do @(posedge clk); while (!evt.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic send_xfer(input logic [7:0] rx);
    send_event(CMD_XFER, 2'($urandom), ADDR_W'($urandom), rand64(), rx);
  endtask

  // Stray transactions: rejected requests, idle exchanges, unused command
  task automatic maybe_noise(input bit mid_access, input int pct);
    if ($urandom_range(0, 99) < pct) begin
      if ($urandom_range(0, 1) == 0)
        send_event(CMD_NONE, 2'($urandom), ADDR_W'($urandom), rand64(), 8'($urandom));
      else if (mid_access)
        send_event(1'($urandom) ? CMD_WRITE : CMD_READ, 2'($urandom), ADDR_W'($urandom),
                   rand64(), 8'($urandom));
      else
        send_xfer(8'($urandom));
    end
  endtask

  // One complete access: request, status polls, optional write enable,
  // opcode and address bytes, then the data bytes
  task automatic do_access(input bit wr, input logic [1:0] size,
                           input logic [ADDR_W-1:0] addr, input logic [63:0] wdata,
                           input int polls, input int pct);
    int n;
    n = sb.byte_count(size);
    maybe_noise(1'b0, pct);
    send_event(wr ? CMD_WRITE : CMD_READ, size, addr, wdata, 8'($urandom));
    for (int p = 0; p <= polls; p++) begin
      maybe_noise(1'b1, pct);
      send_xfer(8'($urandom));
      maybe_noise(1'b1, pct);
      // write in progress stays set until the last poll
      send_xfer((p < polls) ? (8'($urandom) | 8'h01) : (8'($urandom) & 8'hFE));
    end
    if (wr) begin
      maybe_noise(1'b1, pct);
      send_xfer(8'($urandom));
    end
    repeat (3 + n) begin
      maybe_noise(1'b1, pct);
      send_xfer(8'($urandom));
    end
    access_items += 1 + 2 * (polls + 1) + (wr ? 1 : 0) + 3 + n;
  endtask

  task automatic wait_all_results();
    evt.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Stimulus
  initial begin
    bit                drained;
    bit                wr;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
    int                polls;
    sb = new();
    drained        = 1'b0;
    rst            = 1'b1;
    evt.valid      = 1'b0;
    evt.command    = CMD_READ;
    evt.size_code  = SIZE_2;
    evt.address    = '0;
    evt.write_data = '0;
    evt.rx_byte    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle exchange, unused command, size code three read at the top
    // address with one busy poll, short write of all ones with rejects mixed in
    send_xfer(8'hFF);
    send_event(CMD_NONE, SIZE_8_ALT, '1, '1, 8'hFF);
    do_access(1'b0, SIZE_8_ALT, '1, '0, 1, 0);
    do_access(1'b1, SIZE_2, '0, '1, 0, 25);
    wait_all_results();

    // Random accesses with noise; the long result hold-off lands early
    hold_request = 1'b1;
    access_items = 0;
    while (access_items < RANDOM_ITEMS) begin
      wr = 1'($urandom);
      case ($urandom_range(0, 7))
        0:       addr = '0;
        1:       addr = '1;
        default: addr = ADDR_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       wdata = '0;
        1:       wdata = '1;
        default: wdata = rand64();
      endcase
      polls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      do_access(wr, 2'($urandom), addr, wdata, polls, 10);
      if (!drained && access_items >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        wait_all_results();
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("spi_eeprom_word_access regression: pass");
    else
      $display("spi_eeprom_word_access regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("spi_eeprom_word_access regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sew_pkg.sv
hdl/sew_if.sv
hdl/sew_front.sv
hdl/sew_queue.sv
hdl/sew_back.sv
hdl/spi_eeprom_word_access.sv
hdl/sew_check.sv
test/spi_eeprom_word_access_tb.sv
